[hw/rtl/spq_pkg.sv]
package spq_pkg;

	// Queue geometry
	localparam int DEPTH    = 64;
	localparam int KEY_BITS = 64;
	localparam int CNT_W    = $clog2(DEPTH + 1);

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [CNT_W-1:0]    cnt_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	// Command broadcast to every cell of the chain
	typedef struct packed {
		logic ins;
		logic rem;
		key_t key;
	} cell_cmd_t;

endpackage

[hw/rtl/spq_if.sv]
interface spq_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [63:0] key;

	modport source (output valid, output operation, output key, input ready);
	modport sink   (input valid, input operation, input key, output ready);
endinterface

interface spq_rsp_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic        top_valid;
	logic [63:0] top_key;
	logic [6:0]  count;

	modport source (output valid, output accepted, output top_valid, output top_key,
		output count, input ready);
	modport sink   (input valid, input accepted, input top_valid, input top_key,
		input count, output ready);
endinterface

[hw/rtl/spq_cell.sv]
module spq_cell (
	input  logic              clk,
	input  spq_pkg::cell_cmd_t cmd,
	input  logic              live,
	input  logic              left_ge,
	input  spq_pkg::key_t     left_key,
	input  spq_pkg::key_t     right_key,
	output logic              ge,
	output spq_pkg::key_t     key,
	output spq_pkg::key_t     nxt
);
	import spq_pkg::*;

	key_t key_q;

	// A live entry at least as large as the new key stays in place.
	assign ge  = live && (key_q >= cmd.key);
	assign key = key_q;

	always_comb begin
		if (cmd.ins) begin
			if (ge) begin
				nxt = key_q;
			end else if (left_ge) begin
				nxt = cmd.key;
			end else begin
				nxt = left_key;
			end
		end else if (cmd.rem) begin
			nxt = right_key;
		end else begin
			nxt = key_q;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= nxt;
	end

endmodule

[hw/rtl/sorted_priority_queue.sv]
// Sorted priority queue, largest key first. Up to DEPTH (64) keys live in a
// chain of cells, the largest in cell 0. Each request on req is an insert
// (operation 0) or a remove of the top key (operation 1); every request
// returns exactly one response on rsp carrying whether it was carried out,
// the top key and valid flag after it, and the count after it. An insert into
// a full queue or a remove from an empty queue is refused and changes nothing.
// Equal keys leave in arrival order. Each cell compares its key with the
// incoming key in parallel and shifts toward the tail on insert or toward
// the head on remove, all cells updating together: the response is
// registered and appears the cycle after the transfer, and one request per
// cycle is taken while the response side keeps up. Only the low KEY_BITS bits
// of a key are kept. No clearing pass follows reset; the queue is empty and
// ready at once.
module sorted_priority_queue (
	input  logic       clk,
	input  logic       arst_n,
	spq_req_if.sink    req,
	spq_rsp_if.source  rsp
);
	import spq_pkg::*;

	cell_cmd_t cmd;
	logic      fire;
	logic      full;
	logic      empty;
	logic      do_ins;
	logic      do_rem;
	cnt_t      count_q;
	cnt_t      count_d;
	logic      out_valid_q;
	logic      accepted_q;
	logic      top_valid_q;
	key_t      top_key_q;
	cnt_t      out_count_q;

	logic [DEPTH-1:0] live;
	logic [DEPTH-1:0] ge_w;
	key_t             key_w [DEPTH];
	key_t             nxt_w [DEPTH];

	// Take a new request whenever the response register is free or drains now.
	assign req.ready = !out_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;

	assign full   = (count_q == cnt_t'(DEPTH));
	assign empty  = (count_q == '0);
	assign do_ins = fire && (req.operation == OP_INSERT) && !full;
	assign do_rem = fire && (req.operation == OP_REMOVE) && !empty;

	assign cmd.ins = do_ins;
	assign cmd.rem = do_rem;
	assign cmd.key = req.key[KEY_BITS-1:0];

	always_comb begin
		count_d = count_q;
		if (do_ins) begin
			count_d = count_q + cnt_t'(1);
		end else if (do_rem) begin
			count_d = count_q - cnt_t'(1);
		end
	end

	// Cell chain: cell 0 sees a virtual larger neighbor on its left.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic left_ge;
		key_t left_key;
		key_t right_key;

		assign live[i] = (cnt_t'(i) < count_q);

		if (i == 0) begin : g_head
			assign left_ge  = 1'b1;
			assign left_key = '0;
		end else begin : g_body
			assign left_ge  = ge_w[i-1];
			assign left_key = key_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_key = '0;
		end else begin : g_inner
			assign right_key = key_w[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.live      (live[i]),
			.left_ge   (left_ge),
			.left_key  (left_key),
			.right_key (right_key),
			.ge        (ge_w[i]),
			.key       (key_w[i]),
			.nxt       (nxt_w[i])
		);
	end

	// Occupancy and response handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Response payload: state after the request; top is zero once empty.
	always_ff @(posedge clk) begin
		if (fire) begin
			accepted_q  <= do_ins || do_rem;
			top_valid_q <= (count_d != '0);
			top_key_q   <= (count_d != '0) ? nxt_w[0] : '0;
			out_count_q <= count_d;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.accepted  = accepted_q;
	assign rsp.top_valid = top_valid_q;
	assign rsp.top_key   = 64'(top_key_q);
	assign rsp.count     = 7'(out_count_q);

	// Occupancy never runs past the chain length.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(DEPTH))
		else $error("occupancy beyond depth");

	// A refused request leaves the occupancy alone.
	a_refused_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !do_ins && !do_rem) |=> $stable(count_q))
		else $error("refused request changed occupancy");

	// The head of the chain is never smaller than its neighbor.
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		live[1] |-> (key_w[0] >= key_w[1]))
		else $error("chain out of order at head");

endmodule
